// ===== hw/rtl/fbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free block list allocator package
// Shared widths, codes, state types and the result record of the allocator.
// ----------------------------------------------------------------------------
package fbl_pkg;

   localparam int CMD_W      = 2;
   localparam int WORD_W     = 16;
   localparam int KIND_W     = 3;
   localparam int STAT_W     = 3;
   localparam int CNT_W      = 6;
   localparam int DEPTH_DEF  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REFILL = 2'd2
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC_ACK  = 3'd0,
      KIND_FREE_ACK   = 3'd1,
      KIND_SPILL_HDR  = 3'd2,
      KIND_SPILL_ENT  = 3'd3,
      KIND_REFILL_ACK = 3'd4
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_RESERVED = 3'd2,
      STAT_BUSY     = 3'd3,
      STAT_CLAMPED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_COUNT = 2'd1,
      PH_ADDR  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE      = 3'd0,
      S_EMIT      = 3'd1,
      S_ALLOC     = 3'd2,
      S_SPILL_HDR = 3'd3,
      S_SPILL_ENT = 3'd4
   } state_type;

   typedef struct packed {
      kind_type           kind;
      status_type         status;
      logic [WORD_W-1:0]  block_number_res;
      logic               chain_needed;
      logic [WORD_W-1:0]  word;
      logic [CNT_W-1:0]   slot_index;
      logic               last;
   } rsp_type;

   function automatic rsp_type make_rsp(
      input kind_type          kind,
      input status_type        status,
      input logic [WORD_W-1:0] blk,
      input logic              chain,
      input logic [WORD_W-1:0] word,
      input logic [CNT_W-1:0]  slot,
      input logic              last
   );
      rsp_type r;
      r.kind             = kind;
      r.status           = status;
      r.block_number_res = blk;
      r.chain_needed     = chain;
      r.word             = word;
      r.slot_index       = slot;
      r.last             = last;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fbl_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator command channel
// Valid/ready channel carrying one command beat to the allocator.
// ----------------------------------------------------------------------------
interface fbl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] block_number;
   logic [15:0] refill_word;

   modport source (output valid, output command, output block_number,
                   output refill_word, input ready);
   modport sink   (input valid, input command, input block_number,
                   input refill_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fbl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator result channel
// Valid/ready channel carrying one result beat from the allocator.
// ----------------------------------------------------------------------------
interface fbl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [2:0]  status;
   logic [15:0] block_number_res;
   logic        chain_needed;
   logic [15:0] word;
   logic [5:0]  slot_index;
   logic        last;

   modport source (output valid, output kind, output status, output block_number_res,
                   output chain_needed, output word, output slot_index, output last,
                   input ready);
   modport sink   (input valid, input kind, input status, input block_number_res,
                   input chain_needed, input word, input slot_index, input last,
                   output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/free_block_list_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free block list allocator core
// Cached stack of free block numbers with chain refill and spill on overflow.
//
// Commands arrive on req_chan (allocate, free, refill word); results leave on
// rsp_chan, one beat per command, or a header and STACK_DEPTH entry beats
// when a free finds the stack full. The last beat of a command has last set.
// The block takes one command at a time: req_chan.ready is high only while
// the sequencer is idle. A plain command passes through S_EMIT or S_ALLOC,
// which loads its result beat into the output register.
// A spill emits its header, then one entry per cycle while the receiver takes
// beats, set by the stack memory's single read port and the shared step adder.
// Results sit in an output register, so a new command can be taken while
// the previous result waits; a stalled receiver holds the sequencer before
// it loads its next beat and nothing is lost. Synchronous reset empties the
// stack, leaves refill mode and drops any pending beat; the stack memory
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module free_block_list_allocator_core
   import fbl_pkg::*;
#(
   parameter int STACK_DEPTH = DEPTH_DEF
) (
   input  wire        clock,
   input  wire        reset,
   fbl_req_if.sink    req_chan,
   fbl_rsp_if.source  rsp_chan
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   ridx_ff, ridx_in;
   logic [CNT_W-1:0]   sidx_ff, sidx_in;
   logic [WORD_W-1:0]  blk_ff, blk_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [WORD_W-1:0]  stack_ff [STACK_DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [WORD_W-1:0]  wr_data;

   logic [CNT_W-1:0]   step_a;
   logic               step_dec;
   logic [CNT_W-1:0]   step_res;

   cmd_type            cmd;
   logic               accept;
   logic               out_free;
   logic               load_out;
   logic               spill_last;
   logic               go_emit;
   logic               go_alloc;
   logic               go_spill;
   logic [WORD_W-1:0]  n_clamped;

   assign cmd        = cmd_type'(req_chan.command);
   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign spill_last = (sidx_ff == CNT_W'(STACK_DEPTH - 1));
   assign n_clamped  = (req_chan.refill_word > WORD_W'(STACK_DEPTH)) ?
                       WORD_W'(STACK_DEPTH) : req_chan.refill_word;

   // Shared step unit: every count and index increment and decrement goes through this adder.
   always_comb begin
      step_a   = count_ff;
      step_dec = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            case (cmd)
               CMD_ALLOC: begin
                  step_a   = count_ff;
                  step_dec = 1'b1;
               end
               CMD_REFILL: step_a = ridx_ff;
               default:    step_a = count_ff;
            endcase
         end
         S_SPILL_ENT: step_a = sidx_ff;
         default:     step_a = count_ff;
      endcase
   end

   assign step_res = step_dec ? (step_a - CNT_W'(1)) : (step_a + CNT_W'(1));

   // Datapath and register next values.
   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      total_in = total_ff;
      ridx_in  = ridx_ff;
      sidx_in  = sidx_ff;
      blk_in   = blk_ff;
      pend_in  = pend_ff;
      rsp_in   = rsp_ff;
      load_out = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_data  = req_chan.block_number;
      rd_addr  = sidx_ff[AW-1:0];
      go_emit  = 1'b0;
      go_alloc = 1'b0;
      go_spill = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = step_res[AW-1:0];
            if (accept) begin
               case (cmd)
                  CMD_ALLOC: begin
                     if (phase_ff != PH_IDLE) begin
                        pend_in = make_rsp(KIND_ALLOC_ACK, STAT_BUSY, '0, 1'b0, '0, '0, 1'b1);
                        go_emit = 1'b1;
                     end else if (count_ff == '0 || count_ff > CNT_W'(STACK_DEPTH)) begin
                        pend_in = make_rsp(KIND_ALLOC_ACK, STAT_EMPTY, '0, 1'b0, '0, '0, 1'b1);
                        go_emit = 1'b1;
                     end else begin
                        count_in = step_res;
                        if (step_res == '0) begin
                           phase_in = PH_COUNT;
                           total_in = '0;
                           ridx_in  = '0;
                        end
                        go_alloc = 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (phase_ff != PH_IDLE) begin
                        pend_in = make_rsp(KIND_FREE_ACK, STAT_BUSY, req_chan.block_number,
                                           1'b0, '0, '0, 1'b1);
                        go_emit = 1'b1;
                     end else if (req_chan.block_number <= WORD_W'(1)) begin
                        pend_in = make_rsp(KIND_FREE_ACK, STAT_RESERVED, req_chan.block_number,
                                           1'b0, '0, '0, 1'b1);
                        go_emit = 1'b1;
                     end else if (count_ff < CNT_W'(STACK_DEPTH)) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_chan.block_number;
                        count_in = step_res;
                        pend_in  = make_rsp(KIND_FREE_ACK, STAT_OK, req_chan.block_number,
                                            1'b0, '0, '0, 1'b1);
                        go_emit  = 1'b1;
                     end else begin
                        blk_in   = req_chan.block_number;
                        sidx_in  = '0;
                        go_spill = 1'b1;
                     end
                  end
                  CMD_REFILL: begin
                     go_emit = 1'b1;
                     if (phase_ff == PH_COUNT) begin
                        total_in = n_clamped[CNT_W-1:0];
                        ridx_in  = '0;
                        count_in = '0;
                        phase_in = (n_clamped == '0) ? PH_IDLE : PH_ADDR;
                        pend_in  = make_rsp(KIND_REFILL_ACK,
                                            (req_chan.refill_word > WORD_W'(STACK_DEPTH)) ?
                                            STAT_CLAMPED : STAT_OK,
                                            '0, 1'b0, req_chan.refill_word, '0, 1'b1);
                     end else if (phase_ff == PH_ADDR && ridx_ff < total_ff &&
                                  ridx_ff < CNT_W'(STACK_DEPTH)) begin
                        wr_en    = 1'b1;
                        wr_addr  = ridx_ff[AW-1:0];
                        wr_data  = req_chan.refill_word;
                        ridx_in  = step_res;
                        count_in = step_res;
                        if (step_res >= total_ff) begin
                           phase_in = PH_IDLE;
                        end
                        pend_in  = make_rsp(KIND_REFILL_ACK, STAT_OK, '0, 1'b0,
                                            req_chan.refill_word, ridx_ff, 1'b1);
                     end else begin
                        phase_in = PH_IDLE;
                        pend_in  = make_rsp(KIND_REFILL_ACK, STAT_BUSY, '0, 1'b0, '0, '0, 1'b1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_in   = pend_ff;
               load_out = 1'b1;
            end
         end
         S_ALLOC: begin
            rd_addr = count_ff[AW-1:0];
            if (out_free) begin
               rsp_in   = make_rsp(KIND_ALLOC_ACK, STAT_OK, rd_data_ff, (count_ff == '0),
                                   '0, '0, 1'b1);
               load_out = 1'b1;
            end
         end
         S_SPILL_HDR: begin
            if (out_free) begin
               rsp_in   = make_rsp(KIND_SPILL_HDR, STAT_OK, blk_ff, 1'b0,
                                   WORD_W'(STACK_DEPTH), '0, 1'b0);
               load_out = 1'b1;
            end
         end
         S_SPILL_ENT: begin
            if (out_free) begin
               rsp_in   = make_rsp(KIND_SPILL_ENT, STAT_OK, blk_ff, 1'b0, rd_data_ff,
                                   sidx_ff, spill_last);
               load_out = 1'b1;
               sidx_in  = step_res;
               if (spill_last) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = blk_ff;
                  count_in = CNT_W'(1);
               end else begin
                  rd_addr = step_res[AW-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            priority if (go_alloc) begin
               state_in = S_ALLOC;
            end else if (go_spill) begin
               state_in = S_SPILL_HDR;
            end else if (go_emit) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT, S_ALLOC: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         S_SPILL_HDR: begin
            if (load_out) begin
               state_in = S_SPILL_ENT;
            end
         end
         S_SPILL_ENT: begin
            if (load_out && spill_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Port outputs.
   always_comb begin
      req_chan.ready            = (state_ff == S_IDLE);
      rsp_chan.valid            = rsp_valid_ff;
      rsp_chan.kind             = rsp_ff.kind;
      rsp_chan.status           = rsp_ff.status;
      rsp_chan.block_number_res = rsp_ff.block_number_res;
      rsp_chan.chain_needed     = rsp_ff.chain_needed;
      rsp_chan.word             = rsp_ff.word;
      rsp_chan.slot_index       = rsp_ff.slot_index;
      rsp_chan.last             = rsp_ff.last;
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         ridx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         ridx_ff      <= ridx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff <= sidx_in;
      blk_ff  <= blk_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_ff[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("Stack count exceeds the stack depth.");

   a_refill_tracks_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> count_ff == ridx_ff)
      else $error("Refill index and stack count have diverged.");

   a_spill_leaves_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPILL_ENT && load_out && spill_last) |=> count_ff == CNT_W'(1))
      else $error("A spill did not leave the freed block as the only entry.");

endmodule
`default_nettype wire
